/* rtl/fcpa_pkg.sv */
// Package for the fixed chunk pool allocator.
// Holds the field widths, operation and status codes, and the controller state type.
// Depends on nothing.
package fcpa_pkg;

   localparam int SIZE_W       = 17;
   localparam int SLOT_FIELD_W = 10;
   localparam int OFFSET_W     = 26;
   localparam int IN_USE_W     = 11;

   localparam logic [SIZE_W-1:0] CHUNK_SIZE_RESET = 17'd128;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK,
      ST_TOO_LARGE,
      ST_FULL,
      ST_BAD_FREE
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC,
      S_FREE1,
      S_FREE2
   } state_type;

endpackage

/* rtl/fixed_chunk_pool_allocator.sv */
// Fixed chunk pool allocator: order and position tables in two synchronous memories.
// Depends on fcpa_pkg. An allocate or a refused free registers its word in S_ALLOC or S_FREE1,
// a free in S_FREE2; a new request is taken only once busy falls, as the word shows.
// An allocate waits in S_ALLOC for the registered table read; a free needs S_FREE2 as well for its second writes.
// Reset: synchronous; then a clearing pass writes all SLOT_COUNT entries of both tables with the
// identity while busy stays high. The receiver cannot stall: each word shows for one cycle.
module fixed_chunk_pool_allocator
   import fcpa_pkg::*;
#(
   parameter int SLOT_COUNT = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_cmd,
   input  logic [SIZE_W-1:0]       req_request_size,
   input  logic [SLOT_FIELD_W-1:0] req_slot_index,
   output logic                    rsp_valid,
   output logic [SLOT_FIELD_W-1:0] rsp_granted_slot,
   output logic [OFFSET_W-1:0]     rsp_byte_offset,
   output logic [1:0]              rsp_status,
   output logic [IN_USE_W-1:0]     rsp_in_use,
   output logic                    rsp_pool_full,
   input  logic                    csr_wr_en,
   input  logic [SIZE_W-1:0]       csr_wr_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int PROD_W = SLOT_W + SIZE_W;
   localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] INIT_LAST = SLOT_W'(SLOT_COUNT - 1);

   logic [SLOT_W-1:0] order_mem [SLOT_COUNT];
   logic [SLOT_W-1:0] pos_mem   [SLOT_COUNT];

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SLOT_W-1:0]      init_ff, init_in;
   logic [SIZE_W-1:0]      chunk_size_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [SLOT_W-1:0]      order_rd_ff, pos_rd_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0] granted_ff, granted_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   status_type             status_ff, status_in;
   logic [IN_USE_W-1:0]    in_use_ff, in_use_in;
   logic                   full_ff, full_in;

   logic                   accept;
   logic [CNT_W-1:0]       last_pos;
   logic [SLOT_W-1:0]      order_raddr, pos_raddr;
   logic                   order_we, pos_we;
   logic [SLOT_W-1:0]      order_waddr, order_wdata, pos_waddr, pos_wdata;
   logic [PROD_W-1:0]      offset_full;
   logic                   bad_free;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && (state_ff == S_IDLE);
   assign last_pos    = count_ff - 1'b1;
   assign order_raddr = (req_cmd == CMD_FREE) ? SLOT_W'(last_pos) : SLOT_W'(count_ff);
   assign pos_raddr   = SLOT_W'(req_slot_index);
   assign offset_full = PROD_W'(order_rd_ff) * PROD_W'(chunk_size_ff);
   assign bad_free    = (32'(slot_ff) >= 32'(SLOT_COUNT)) || (count_ff == '0) ||
                        (CNT_W'(pos_rd_ff) >= count_ff);

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_raddr];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         count_ff      <= '0;
         init_ff       <= '0;
         chunk_size_ff <= CHUNK_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            chunk_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         size_ff <= req_request_size;
         slot_ff <= req_slot_index;
      end
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
      status_ff  <= status_in;
      in_use_ff  <= in_use_in;
      full_ff    <= full_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      init_in      = init_ff;
      order_we     = 1'b0;
      order_waddr  = '0;
      order_wdata  = '0;
      pos_we       = 1'b0;
      pos_waddr    = '0;
      pos_wdata    = '0;
      rsp_valid_in = 1'b0;
      granted_in   = '0;
      offset_in    = '0;
      status_in    = ST_OK;
      unique case (state_ff)
         S_INIT: begin
            order_we    = 1'b1;
            order_waddr = init_ff;
            order_wdata = init_ff;
            pos_we      = 1'b1;
            pos_waddr   = init_ff;
            pos_wdata   = init_ff;
            init_in     = init_ff + 1'b1;
            if (init_ff == INIT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = (req_cmd == CMD_FREE) ? S_FREE1 : S_ALLOC;
            end
         end
         S_ALLOC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (size_ff > chunk_size_ff) begin
               status_in = ST_TOO_LARGE;
            end else if (count_ff == COUNT_MAX) begin
               status_in = ST_FULL;
            end else begin
               granted_in = SLOT_FIELD_W'(order_rd_ff);
               offset_in  = OFFSET_W'(offset_full);
               count_in   = count_ff + 1'b1;
            end
         end
         S_FREE1: begin
            if (bad_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_BAD_FREE;
               state_in     = S_IDLE;
            end else begin
               order_we    = 1'b1;
               order_waddr = pos_rd_ff;
               order_wdata = order_rd_ff;
               pos_we      = 1'b1;
               pos_waddr   = order_rd_ff;
               pos_wdata   = pos_rd_ff;
               state_in    = S_FREE2;
            end
         end
         S_FREE2: begin
            order_we     = 1'b1;
            order_waddr  = SLOT_W'(last_pos);
            order_wdata  = SLOT_W'(slot_ff);
            pos_we       = 1'b1;
            pos_waddr    = SLOT_W'(slot_ff);
            pos_wdata    = SLOT_W'(last_pos);
            count_in     = last_pos;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      in_use_in = IN_USE_W'(count_in);
      full_in   = (count_in == COUNT_MAX);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_byte_offset  = offset_ff;
   assign rsp_status       = status_ff;
   assign rsp_in_use       = in_use_ff;
   assign rsp_pool_full    = full_ff;

endmodule

/* rtl/fcpa_checker.sv */
// Port checker for the fixed chunk pool allocator, with the bind that attaches it.
// Depends on fcpa_pkg and the ports of fixed_chunk_pool_allocator.
module fcpa_checker
   import fcpa_pkg::*;
#(
   parameter int SLOT_COUNT = 1024
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [SLOT_FIELD_W-1:0] rsp_granted_slot,
   input logic [OFFSET_W-1:0]     rsp_byte_offset,
   input logic [1:0]              rsp_status,
   input logic [IN_USE_W-1:0]     rsp_in_use,
   input logic                    rsp_pool_full
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted word");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result words came in back-to-back cycles");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         ((rsp_granted_slot == '0) && (rsp_byte_offset == '0)))
      else $error("refused operation returned a slot or offset");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pool_full == (32'(rsp_in_use) == 32'(SLOT_COUNT))))
      else $error("pool full flag disagrees with the in-use count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> rsp_pool_full)
      else $error("pool full status without the pool full flag");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_fcpa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_byte_offset  (rsp_byte_offset),
   .rsp_status       (rsp_status),
   .rsp_in_use       (rsp_in_use),
   .rsp_pool_full    (rsp_pool_full)
);

/* tb/pool_grant_checker.sv */
`timescale 1ns / 1ps
// Checker for the fixed chunk pool allocator: it predicts the order table, position table
// and chunk count, and compares each result word with the oldest prediction.
// Depends on fcpa_pkg.
module pool_grant_checker
   import fcpa_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_cmd,
   input  logic [SIZE_W-1:0]       req_request_size,
   input  logic [SLOT_FIELD_W-1:0] req_slot_index,
   input  logic                    rsp_valid,
   input  logic [SLOT_FIELD_W-1:0] rsp_granted_slot,
   input  logic [OFFSET_W-1:0]     rsp_byte_offset,
   input  logic [1:0]              rsp_status,
   input  logic [IN_USE_W-1:0]     rsp_in_use,
   input  logic                    rsp_pool_full,
   input  logic                    csr_wr_en,
   input  logic [SIZE_W-1:0]       csr_wr_data,
   output int                      mismatch_count,
   output int                      words_pending
);

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] slot;
      logic [OFFSET_W-1:0]     offset;
      status_type              status;
      logic [IN_USE_W-1:0]     in_use;
      logic                    full;
   } pool_word_type;

   logic [SLOT_FIELD_W-1:0] order_tbl [SLOTS];
   logic [SLOT_FIELD_W-1:0] place_tbl [SLOTS];
   logic [IN_USE_W-1:0]     used;
   logic [SIZE_W-1:0]       chunk;
   pool_word_type           expected_grants [$];

   task automatic predict_pool_op(input logic cmd, input logic [SIZE_W-1:0] req_bytes,
                                  input logic [SLOT_FIELD_W-1:0] slot);
      pool_word_type                  w;
      logic [SLOT_FIELD_W-1:0]        mover;
      logic [SLOT_FIELD_W-1:0]        hole;
      logic [SLOT_FIELD_W-1:0]        tail;
      logic [SLOT_FIELD_W+SIZE_W-1:0] product;
      w = '0;
      w.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
         if (req_bytes > chunk) begin
            w.status = ST_TOO_LARGE;
         end else if (used >= SLOTS) begin
            w.status = ST_FULL;
         end else begin
            w.slot = order_tbl[used[SLOT_FIELD_W-1:0]];
            product = w.slot * chunk;
            w.offset = product[OFFSET_W-1:0];
            used = used + 1'b1;
         end
      end else if (slot >= SLOTS || used == 0 || place_tbl[slot] >= used) begin
         w.status = ST_BAD_FREE;
      end else begin
         hole = place_tbl[slot];
         tail = SLOT_FIELD_W'(used - 1'b1);
         mover = order_tbl[tail];
         order_tbl[hole] = mover;
         order_tbl[tail] = slot;
         place_tbl[mover] = hole;
         place_tbl[slot] = tail;
         used = used - 1'b1;
      end
      w.in_use = used;
      w.full = (used == SLOTS);
      expected_grants.push_back(w);
   endtask

   task automatic check_word();
      pool_word_type w;
      if (expected_grants.size() == 0) begin
         $error("result word arrived with none expected");
         mismatch_count++;
      end else begin
         w = expected_grants.pop_front();
         if (rsp_granted_slot !== w.slot) begin
            $error("granted_slot: expected %0d, got %0d", w.slot, rsp_granted_slot);
            mismatch_count++;
         end
         if (rsp_byte_offset !== w.offset) begin
            $error("byte_offset: expected %0d, got %0d", w.offset, rsp_byte_offset);
            mismatch_count++;
         end
         if (rsp_status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, rsp_status);
            mismatch_count++;
         end
         if (rsp_in_use !== w.in_use) begin
            $error("in_use: expected %0d, got %0d", w.in_use, rsp_in_use);
            mismatch_count++;
         end
         if (rsp_pool_full !== w.full) begin
            $error("pool_full: expected %0d, got %0d", w.full, rsp_pool_full);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            order_tbl[i] = SLOT_FIELD_W'(i);
            place_tbl[i] = SLOT_FIELD_W'(i);
         end
         used = '0;
         chunk = CHUNK_SIZE_RESET;
         expected_grants.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            chunk = csr_wr_data;
         end
         if (rsp_valid) begin
            check_word();
         end
         if (start && !busy) begin
            predict_pool_op(req_cmd, req_request_size, req_slot_index);
         end
      end
      words_pending = expected_grants.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the fixed chunk pool allocator: clock, reset, allocate and free
// commands, chunk size writes and the verdict. Depends on fcpa_pkg, the allocator
// and pool_grant_checker.
module tb_top
   import fcpa_pkg::*;
();

   localparam int SLOTS = 1024;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_cmd = CMD_ALLOC;
   logic [SIZE_W-1:0]       req_request_size = '0;
   logic [SLOT_FIELD_W-1:0] req_slot_index = '0;
   logic                    rsp_valid;
   logic [SLOT_FIELD_W-1:0] rsp_granted_slot;
   logic [OFFSET_W-1:0]     rsp_byte_offset;
   logic [1:0]              rsp_status;
   logic [IN_USE_W-1:0]     rsp_in_use;
   logic                    rsp_pool_full;
   logic                    csr_wr_en = 1'b0;
   logic [SIZE_W-1:0]       csr_wr_data = '0;
   int                      mismatch_count;
   int                      words_pending;

   logic [SIZE_W-1:0]       chunk_now = CHUNK_SIZE_RESET;
   logic [SLOT_FIELD_W-1:0] live_slots [$];
   bit                      accepted = 1'b0;
   bit                      awaiting = 1'b0;
   bit                      gaps_on = 1'b1;
   logic                    pend_cmd = CMD_ALLOC;
   logic [SLOT_FIELD_W-1:0] pend_slot = '0;

   always #4 clock = ~clock;

   fixed_chunk_pool_allocator #(.SLOT_COUNT(SLOTS)) u_dut (.*);

   pool_grant_checker #(.SLOTS(SLOTS)) u_checker (.*);

   // The live slot list follows the result words so that most frees hit slots in use.
   task automatic step_clock();
      @(posedge clock);
      accepted = 1'b0;
      if (!reset && rsp_valid) begin
         awaiting = 1'b0;
         if (rsp_status == ST_OK) begin
            if (pend_cmd == CMD_ALLOC) begin
               live_slots.push_back(rsp_granted_slot);
            end else begin
               for (int i = 0; i < live_slots.size(); i++) begin
                  if (live_slots[i] == pend_slot) begin
                     live_slots.delete(i);
                     break;
                  end
               end
            end
         end
      end
      if (!reset && start && !busy) begin
         accepted = 1'b1;
         awaiting = 1'b1;
         pend_cmd = req_cmd;
         pend_slot = req_slot_index;
      end
   endtask

   task automatic issue_op(input logic cmd, input logic [SIZE_W-1:0] req_bytes,
                           input logic [SLOT_FIELD_W-1:0] slot);
      if (gaps_on) begin
         while ($urandom_range(99) < 29) begin
            start <= 1'b0;
            step_clock();
         end
      end
      req_cmd <= cmd;
      req_request_size <= req_bytes;
      req_slot_index <= slot;
      start <= 1'b1;
      do step_clock(); while (!accepted);
   endtask

   task automatic random_op(input int alloc_pct, input int fit_pct);
      logic [SIZE_W-1:0]       req_bytes;
      logic [SLOT_FIELD_W-1:0] slot;
      int                      pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         if (pick < fit_pct) begin
            req_bytes = SIZE_W'($urandom_range(int'(chunk_now), 0));
         end else if (pick < 95 && chunk_now != '1) begin
            req_bytes = SIZE_W'($urandom_range(17'h1FFFF, int'(chunk_now) + 1));
         end else begin
            req_bytes = SIZE_W'($urandom);
         end
         issue_op(CMD_ALLOC, req_bytes, SLOT_FIELD_W'($urandom));
      end else begin
         if (live_slots.size() != 0 && $urandom_range(99) < 80) begin
            slot = live_slots[$urandom_range(live_slots.size() - 1)];
         end else begin
            slot = SLOT_FIELD_W'($urandom);
         end
         issue_op(CMD_FREE, SIZE_W'($urandom), slot);
      end
   endtask

   task automatic go_idle();
      start <= 1'b0;
      step_clock();
      while (awaiting) step_clock();
   endtask

   task automatic write_chunk(input logic [SIZE_W-1:0] value);
      go_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      chunk_now = value;
      step_clock();
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int                      n;
      logic [SLOT_FIELD_W-1:0] victim;
      repeat (2) step_clock();
      reset <= 1'b0;

      issue_op(CMD_FREE, 17'd0, 10'd0);
      issue_op(CMD_FREE, 17'h1FFFF, 10'd1023);
      issue_op(CMD_ALLOC, 17'd0, 10'd682);
      issue_op(CMD_ALLOC, 17'd128, 10'd341);
      issue_op(CMD_ALLOC, 17'd129, 10'd0);
      issue_op(CMD_ALLOC, 17'd65535, 10'd1023);
      issue_op(CMD_ALLOC, 17'd65536, 10'd0);
      issue_op(CMD_ALLOC, 17'h1FFFF, 10'd0);
      issue_op(CMD_FREE, 17'd0, 10'd0);
      issue_op(CMD_FREE, 17'd0, 10'd0);
      issue_op(CMD_ALLOC, 17'd1, 10'd0);
      issue_op(CMD_ALLOC, 17'd127, 10'd0);
      issue_op(CMD_FREE, 17'd0, 10'd1);
      issue_op(CMD_FREE, 17'd0, 10'd682);
      issue_op(CMD_FREE, 17'd0, 10'd341);
      issue_op(CMD_ALLOC, 17'd64, 10'd0);
      issue_op(CMD_FREE, 17'd0, 10'd2);
      issue_op(CMD_FREE, 17'd0, 10'd0);
      issue_op(CMD_FREE, 17'd0, 10'd1);
      issue_op(CMD_FREE, 17'd0, 10'd1023);

      write_chunk(17'd1);
      repeat (50) random_op(50, 75);

      // Fill the pool, the first part with no gaps at all.
      write_chunk(17'd65536);
      gaps_on = 1'b0;
      n = 0;
      while (live_slots.size() < SLOTS) begin
         random_op(97, 95);
         n++;
         if (n == 400) gaps_on = 1'b1;
      end
      gaps_on = 1'b1;
      go_idle();
      issue_op(CMD_ALLOC, 17'd0, 10'd0);
      issue_op(CMD_ALLOC, 17'd65537, 10'd0);
      issue_op(CMD_ALLOC, 17'd65536, 10'd0);
      victim = live_slots[$urandom_range(live_slots.size() - 1)];
      issue_op(CMD_FREE, 17'd0, victim);
      issue_op(CMD_ALLOC, 17'd65536, 10'd0);
      issue_op(CMD_ALLOC, 17'd1, 10'd0);

      write_chunk(17'h1FFFF);
      repeat (40) random_op(50, 75);
      write_chunk(17'd0);
      repeat (40) random_op(45, 75);
      write_chunk(SIZE_W'($urandom_range(65536, 1)));
      repeat (40) random_op(40, 75);

      go_idle();
      repeat (4) step_clock();
      if (words_pending != 0) begin
         $error("%0d result words never arrived", words_pending);
      end
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
